// ----- rtl/gvh_pkg.sv -----
package gvh_pkg;

  typedef enum logic [2:0] {
    REQ_INIT   = 3'd0,
    REQ_DEC    = 3'd1,
    REQ_SET    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_INSERT = 3'd4,
    REQ_QUERY  = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_IN_HEAP   = 3'd3,
    ST_NOT_IN    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_FIRST_BLOCK = 1'd0,
    CFG_BLOCKS      = 1'd1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POS,
    S_ELEM,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_RD2,
    S_DN_CMP,
    S_TOP_RD,
    S_TOP_WT
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  bank;
    logic [15:0] block;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        heap_empty;
    logic [15:0] victim_block;
    logic [15:0] victim_count;
  } out_t;

endpackage

// ----- rtl/gvh_ram.sv -----
module gvh_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gc_victim_indexed_min_heap.sv -----
// Channel  | Direction | Handshake              | Payload
// cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// request  | in        | in_valid_i/in_ready_o  | in_data_i (gvh_pkg::in_t)
// result   | out       | out_valid_o/out_ready_i| out_data_o (gvh_pkg::out_t)
//
// One request at a time. A request that touches no slot goes straight to the
// report steps; a plain slot update first reads the position, then the element;
// a sift adds a parent read and a compare per level up, or a read of each child
// and a compare per level down, since the slot memory has a single read port.
// Init writes one slot per cycle, for every block in use of every bank,
// then reports.
// Reset clears the controller, the heap sizes and the latched block count; the
// memories hold garbage until the first init request.
// A finished result waits in the output register; the next request is taken
// while it waits, and only the report step holds if it is still not taken.
module gc_victim_indexed_min_heap #(
  parameter int NUM_BANK_HEAPS      = 8,
  parameter int MAX_BLOCKS_PER_BANK = 256,
  parameter int COUNT_WIDTH         = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gvh_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gvh_pkg::out_t out_data_o
);
  import gvh_pkg::*;

  localparam int BKW = (NUM_BANK_HEAPS > 1) ? $clog2(NUM_BANK_HEAPS) : 1;
  localparam int LW  = $clog2(MAX_BLOCKS_PER_BANK);      // logical block number
  localparam int SW  = $clog2(MAX_BLOCKS_PER_BANK + 1);  // slot index / size
  localparam int CW  = COUNT_WIDTH;
  localparam int EW  = LW + CW;                          // slot entry {block, count}
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  // configuration
  logic [15:0] first_block_q;
  logic [8:0]  blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_block_q <= '0;
      blocks_q      <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_FIRST_BLOCK: first_block_q <= cfg_wdata_i;
        CFG_BLOCKS:      blocks_q      <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // memories
  logic                slot_we, pos_we;
  logic [BKW+SW-1:0]   slot_wa, slot_ra;
  logic [EW-1:0]       slot_wd, slot_rd;
  logic [BKW+LW-1:0]   pos_wa, pos_ra;
  logic [SW-1:0]       pos_wd, pos_rd;

  gvh_ram #(.AW(BKW + SW), .DW(EW)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(slot_wa), .wdata_i(slot_wd),
    .raddr_i(slot_ra), .rdata_o(slot_rd)
  );

  gvh_ram #(.AW(BKW + LW), .DW(SW)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd)
  );

  // controller state
  state_e         state_q, state_d;
  in_t            req_q, req_d;
  logic [2:0]     status_q, status_d;
  logic [SW-1:0]  p_q, p_d, h_q, h_d;
  logic [EW-1:0]  cur_q, cur_d, ch1_q, ch1_d;
  logic           has2_q, has2_d, moved_q, moved_d;
  logic [BKW-1:0] ib_q, ib_d;
  logic [LW-1:0]  ii_q, ii_d;
  logic [15:0]    act_first_q, act_first_d;
  logic [SW-1:0]  act_blocks_q, act_blocks_d;
  logic [SW-1:0]  size_q [NUM_BANK_HEAPS];
  logic [SW-1:0]  size_d [NUM_BANK_HEAPS];
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;

  // helpers
  logic [BKW+2:0] bank_in_ext, bank_q_ext;
  logic [BKW-1:0] bidx_in, bidx;
  logic           bank_ok_in, bank_ok;
  logic [15:0]    lb_in;
  logic [SW-1:0]  size_cur, n_clamp;
  logic [CW-1:0]  val;
  logic [SW:0]    c1, c2;
  logic           pick2;
  logic [EW-1:0]  mch;

  assign bank_in_ext = {{BKW{1'b0}}, in_data_i.bank};
  assign bank_q_ext  = {{BKW{1'b0}}, req_q.bank};
  assign bidx_in     = bank_in_ext[BKW-1:0];
  assign bidx        = bank_q_ext[BKW-1:0];
  assign bank_ok_in  = 32'(in_data_i.bank) < NUM_BANK_HEAPS;
  assign bank_ok     = 32'(req_q.bank) < NUM_BANK_HEAPS;
  assign lb_in       = in_data_i.block - act_first_q;
  assign size_cur    = bank_ok ? size_q[bidx] : '0;
  assign val         = (32'(req_q.amount) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                           : req_q.amount[CW-1:0];
  assign c1          = {h_q, 1'b0};
  assign c2          = c1 + (SW+1)'(1);
  // equal children go right
  assign pick2       = has2_q && !(ch1_q[CW-1:0] < slot_rd[CW-1:0]);
  assign mch         = pick2 ? slot_rd : ch1_q;

  always_comb begin
    logic [31:0] n32;
    n32 = 32'(blocks_q);
    if (n32 < 32'd1) n32 = 32'd1;
    if (n32 > 32'(MAX_BLOCKS_PER_BANK)) n32 = 32'(MAX_BLOCKS_PER_BANK);
    n_clamp = n32[SW-1:0];
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    status_d     = status_q;
    p_d          = p_q;
    h_d          = h_q;
    cur_d        = cur_q;
    ch1_d        = ch1_q;
    has2_d       = has2_q;
    moved_d      = moved_q;
    ib_d         = ib_q;
    ii_d         = ii_q;
    act_first_d  = act_first_q;
    act_blocks_d = act_blocks_q;
    size_d       = size_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    slot_we      = 1'b0;
    slot_wa      = '0;
    slot_wd      = '0;
    pos_we       = 1'b0;
    pos_wa       = '0;
    pos_wd       = '0;
    slot_ra      = {bidx, SW'(1)};
    pos_ra       = {bidx_in, lb_in[LW-1:0]};
    in_ready_o   = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          status_d = ST_OK;
          moved_d  = 1'b0;
          if (in_data_i.req_type == REQ_INIT) begin
            act_first_d  = first_block_q;
            act_blocks_d = n_clamp;
            ib_d         = '0;
            ii_d         = '0;
            for (int b = 0; b < NUM_BANK_HEAPS; b++) size_d[b] = '0;
            state_d = S_INIT;
          end else if (!bank_ok_in) begin
            status_d = ST_RANGE;
            state_d  = S_TOP_RD;
          end else if (in_data_i.req_type >= REQ_DEC && in_data_i.req_type <= REQ_INSERT)
          begin
            if (32'(lb_in) >= 32'(act_blocks_q)) begin
              status_d = ST_RANGE;
              state_d  = S_TOP_RD;
            end else begin
              state_d = S_POS;  // position read issued now
            end
          end else begin
            state_d = S_TOP_RD;
          end
        end
      end

      S_INIT: begin
        slot_we = 1'b1;
        slot_wa = {ib_q, SW'(ii_q) + SW'(1)};
        slot_wd = {ii_q, val};
        pos_we  = 1'b1;
        pos_wa  = {ib_q, ii_q};
        pos_wd  = SW'(ii_q) + SW'(1);
        if (SW'(ii_q) == act_blocks_q - SW'(1)) begin
          ii_d = '0;
          ib_d = ib_q + BKW'(1);
          if (32'(ib_q) == NUM_BANK_HEAPS - 1) state_d = S_TOP_RD;
        end else begin
          ii_d = ii_q + LW'(1);
        end
      end

      S_POS: begin
        p_d     = pos_rd;
        slot_ra = {bidx, pos_rd};
        state_d = S_ELEM;
      end

      S_ELEM: begin
        state_d = S_TOP_RD;
        case (req_e'(req_q.req_type))
          REQ_DEC: begin
            if (slot_rd[CW-1:0] == '0 || 32'(req_q.amount) > 32'(slot_rd[CW-1:0])) begin
              status_d = ST_UNDERFLOW;
            end else begin
              cur_d   = {slot_rd[EW-1:CW], slot_rd[CW-1:0] - req_q.amount[CW-1:0]};
              slot_we = 1'b1;
              slot_wa = {bidx, p_q};
              slot_wd = cur_d;
              if (p_q <= size_cur) begin
                h_d     = p_q;
                state_d = S_UP_RD;
              end
            end
          end
          REQ_SET: begin
            if (p_q <= size_cur) begin
              status_d = ST_IN_HEAP;
            end else begin
              slot_we = 1'b1;
              slot_wa = {bidx, p_q};
              slot_wd = {slot_rd[EW-1:CW], val};
            end
          end
          REQ_REMOVE: begin
            if (p_q > size_cur) begin
              status_d = ST_NOT_IN;
            end else begin
              cur_d   = {slot_rd[EW-1:CW], val};
              slot_ra = {bidx, size_cur};
              state_d = S_LAST;
            end
          end
          REQ_INSERT: begin
            if (p_q <= size_cur) begin
              status_d = ST_IN_HEAP;
            end else begin
              cur_d   = slot_rd;
              slot_ra = {bidx, size_cur + SW'(1)};
              state_d = S_LAST;
            end
          end
          default: ;
        endcase
      end

      S_LAST: begin
        state_d = S_TOP_RD;
        if (req_q.req_type == REQ_REMOVE) begin
          // park the removed block at the old last slot
          slot_we = 1'b1;
          slot_wa = {bidx, size_cur};
          slot_wd = cur_q;
          pos_we  = 1'b1;
          pos_wa  = {bidx, cur_q[EW-1:CW]};
          pos_wd  = size_cur;
          size_d[bidx] = size_cur - SW'(1);
          if (p_q < size_cur) begin
            cur_d   = slot_rd;
            h_d     = p_q;
            state_d = S_UP_RD;
          end
        end else begin
          // move the old occupant of the new last slot into the freed slot
          slot_we = 1'b1;
          slot_wa = {bidx, p_q};
          slot_wd = slot_rd;
          pos_we  = 1'b1;
          pos_wa  = {bidx, slot_rd[EW-1:CW]};
          pos_wd  = p_q;
          size_d[bidx] = size_cur + SW'(1);
          h_d     = size_cur + SW'(1);
          state_d = S_UP_RD;
        end
      end

      S_UP_RD: begin
        if (h_q > SW'(1)) begin
          slot_ra = {bidx, h_q >> 1};
          state_d = S_UP_CMP;
        end else if (req_q.req_type == REQ_REMOVE && !moved_q) begin
          state_d = S_DN_CHK;
        end else begin
          slot_we = 1'b1;
          slot_wa = {bidx, h_q};
          slot_wd = cur_q;
          pos_we  = 1'b1;
          pos_wa  = {bidx, cur_q[EW-1:CW]};
          pos_wd  = h_q;
          state_d = S_TOP_RD;
        end
      end

      S_UP_CMP: begin
        if (cur_q[CW-1:0] < slot_rd[CW-1:0]) begin
          slot_we = 1'b1;
          slot_wa = {bidx, h_q};
          slot_wd = slot_rd;
          pos_we  = 1'b1;
          pos_wa  = {bidx, slot_rd[EW-1:CW]};
          pos_wd  = h_q;
          h_d     = h_q >> 1;
          moved_d = 1'b1;
          state_d = S_UP_RD;
        end else if (req_q.req_type == REQ_REMOVE && !moved_q) begin
          state_d = S_DN_CHK;
        end else begin
          slot_we = 1'b1;
          slot_wa = {bidx, h_q};
          slot_wd = cur_q;
          pos_we  = 1'b1;
          pos_wa  = {bidx, cur_q[EW-1:CW]};
          pos_wd  = h_q;
          state_d = S_TOP_RD;
        end
      end

      S_DN_CHK: begin
        if (c1 > {1'b0, size_cur}) begin
          slot_we = 1'b1;
          slot_wa = {bidx, h_q};
          slot_wd = cur_q;
          pos_we  = 1'b1;
          pos_wa  = {bidx, cur_q[EW-1:CW]};
          pos_wd  = h_q;
          state_d = S_TOP_RD;
        end else begin
          slot_ra = {bidx, c1[SW-1:0]};
          state_d = S_DN_RD2;
        end
      end

      S_DN_RD2: begin
        ch1_d   = slot_rd;
        has2_d  = c2 <= {1'b0, size_cur};
        slot_ra = {bidx, c2[SW-1:0]};
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        slot_we = 1'b1;
        slot_wa = {bidx, h_q};
        pos_we  = 1'b1;
        pos_wd  = h_q;
        if (cur_q[CW-1:0] <= mch[CW-1:0]) begin
          slot_wd = cur_q;
          pos_wa  = {bidx, cur_q[EW-1:CW]};
          state_d = S_TOP_RD;
        end else begin
          slot_wd = mch;
          pos_wa  = {bidx, mch[EW-1:CW]};
          h_d     = pick2 ? c2[SW-1:0] : c1[SW-1:0];
          state_d = S_DN_CHK;
        end
      end

      S_TOP_RD: begin
        state_d = S_TOP_WT;
      end

      S_TOP_WT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.status   = status_q;
          if (size_cur != '0) begin
            out_d.heap_empty   = 1'b0;
            out_d.victim_block = 16'(slot_rd[EW-1:CW]) + act_first_q;
            out_d.victim_count = 16'(slot_rd[CW-1:0]);
          end else begin
            out_d.heap_empty   = 1'b1;
            out_d.victim_block = '0;
            out_d.victim_count = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      act_blocks_q <= '0;
      act_first_q  <= '0;
      for (int b = 0; b < NUM_BANK_HEAPS; b++) size_q[b] <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      act_blocks_q <= act_blocks_d;
      act_first_q  <= act_first_d;
      size_q       <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    p_q      <= p_d;
    h_q      <= h_d;
    cur_q    <= cur_d;
    ch1_q    <= ch1_d;
    has2_q   <= has2_d;
    moved_q  <= moved_d;
    ib_q     <= ib_d;
    ii_q     <= ii_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/gvh_checker.sv -----
module gvh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input gvh_pkg::out_t out_data_o
);
  import gvh_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an empty heap reports no victim
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.heap_empty |->
      out_data_o.victim_block == 16'd0 && out_data_o.victim_count == 16'd0)
    else $error("empty heap with victim data");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_NOT_IN)
    else $error("bad status code");

endmodule

bind gc_victim_indexed_min_heap gvh_checker u_gvh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
